FILE: design/twirl_warp_map_generator_macros.svh
// Assertion macros for the twirl warp map generator.
// Used by design/twirl_warp_map_generator.sv; expects clk and rst_n in scope.
`ifndef TWIRL_WARP_MAP_GENERATOR_MACROS_SVH
`define TWIRL_WARP_MAP_GENERATOR_MACROS_SVH

// same-cycle implication, off during reset
`define TWMG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TWMG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/twmg_pkg.sv
// Package for the twirl warp map generator: widths, angle constants, arctan table,
// payload structs and register indexes. No dependencies.
`timescale 1ns / 1ps
package twmg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;

  localparam int ATAN_LEN = 24;
  localparam int NSTEP    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam int PIX_W     = 12;
  localparam int OUT_W     = 24;
  localparam int SIZE_W    = 13;
  localparam int TWIST_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // position / size width, offset width
  localparam int PW  = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
  localparam int DW  = PW + 1;
  localparam int R2W = 2 * COORD_BITS + 2;
  localparam int RW  = (R2W + 2 * FRAC_BITS + 1) / 2;   // root width
  localparam int ANG_SH = 18;                           // Q12 -> Q30
  localparam int MAG_W  = TWIST_W;
  localparam int NUM_W  = MAG_W + RW;
  localparam int QW     = MAG_W + ANG_SH;               // quotient bits
  localparam int ZW     = QW + 2;
  localparam int XW     = DW + 32;
  localparam int RSH    = 30 - FRAC_BITS;

  localparam logic [PW-1:0] SIZE_MAX = PW'(1) << COORD_BITS;

  localparam logic signed [ZW-1:0] ANG_PI      = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = ZW'(64'sd6746518852);
  localparam logic signed [31:0]   INV_GAIN    = 32'sd652032874;

  localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_TWIST_ANGLE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] source_x;
    logic signed [OUT_W-1:0] source_y;
    logic                    center_invalid;
  } out_item_t;

endpackage

FILE: design/twirl_warp_map_generator.sv
// Twirl warp map generator: pixel position in, twirled source coordinate out.
// Depends on twmg_pkg and twirl_warp_map_generator_macros.svh.
`timescale 1ns / 1ps
`include "twirl_warp_map_generator_macros.svh"

// One transaction per clock in each direction while out_stall does not hold the
// output. Each pixel position runs down a fixed pipeline of 3 + RW + 1 + QW +
// 3 + NSTEP + 1 stages: offset from the centre, squares, square sums, two
// bit-serial square roots in lock-step (|d| and rmax, RW stages), the twist
// product, a restoring divider (QW stages), angle wrap, CORDIC gain, quarter
// turn, one stage per CORDIC step, then the output register. Everything moves
// on one advance signal, so in_stall is high only while a result sits in the
// output register under out_stall; nothing is dropped or repeated. Registers
// are written through cfg_we/cfg_index/cfg_wdata and must only change while no
// transaction is in flight; centre defaults, clamped sizes, rmax corner
// distances and the twist magnitude are derived straight from them. center_x
// and center_y both zero select the image centre; a centre beyond the image
// gives the identity map with center_invalid set, and a pixel further out than
// rmax is also passed through unchanged. Outputs are signed with FRAC_BITS
// fraction bits, saturated to 24 bits.
module twirl_warp_map_generator import twmg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int NST = 3 + RW + 1 + QW + 3 + NSTEP + 1;

  localparam logic signed [XW-1:0] RND    = XW'(1) << (RSH - 1);
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic                  far;
  } side_t;

  typedef struct packed {
    logic [RW+1:0] rem;
    logic [RW-1:0] res;
  } sq_t;

  typedef struct packed {
    side_t          side;
    logic [R2W-1:0] r2;
    logic [R2W-1:0] rm2;
    sq_t            a;
    sq_t            b;
  } sq_stage_t;

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] num;
    logic [RW-1:0]    div;
    logic [RW-1:0]    rem;
    logic [QW-1:0]    q;
  } dv_stage_t;

  typedef struct packed {
    side_t                side;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cd_stage_t;

  function automatic sq_t sq_step(input sq_t s, input logic [1:0] pair);
    logic [RW+1:0] acc;
    logic [RW+1:0] trial;
    sq_t           o;
    acc   = {s.rem[RW-1:0], pair};
    trial = {s.res, 2'b01};
    if (acc >= trial) begin
      o.rem = acc - trial;
      o.res = {s.res[RW-2:0], 1'b1};
    end else begin
      o.rem = acc;
      o.res = {s.res[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  // two-bit group j of (v << 2*FRAC_BITS)
  function automatic logic [1:0] get_pair(input logic [R2W-1:0] v, input int j);
    if (j < FRAC_BITS) return 2'b00;
    return v[2*(j-FRAC_BITS) +: 2];
  endfunction

  // bit i of (num << ANG_SH)
  function automatic logic div_bit(input logic [NUM_W-1:0] num, input int i);
    if (i < ANG_SH) return 1'b0;
    return num[i-ANG_SH];
  endfunction

  function automatic logic [PW-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [PW-1:0] ve;
    ve = PW'(v);
    if (v == '0) return PW'(1);
    if (ve > SIZE_MAX) return SIZE_MAX;
    return ve;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [XW-1:0] v);
    if (v > SAT_HI) return SAT_HI[OUT_W-1:0];
    if (v < SAT_LO) return SAT_LO[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  logic [SIZE_W-1:0]  width_r, height_r, cx_cfg_r, cy_cfg_r;
  logic [TWIST_W-1:0] twist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(1);
      height_r <= SIZE_W'(1);
      cx_cfg_r <= '0;
      cy_cfg_r <= '0;
      twist_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_CENTER_X:     cx_cfg_r <= cfg_wdata[SIZE_W-1:0];
        CFG_CENTER_Y:     cy_cfg_r <= cfg_wdata[SIZE_W-1:0];
        CFG_TWIST_ANGLE:  twist_r  <= cfg_wdata[TWIST_W-1:0];
        default: ;
      endcase
    end
  end

  // register-derived, user must keep static while transactions are in flight
  logic [PW-1:0]        w_eff, h_eff, cx_eff, cy_eff, mx_eff, my_eff;
  logic signed [PW+1:0] wrem, hrem;
  logic                 ctr_bad, use_mid, aneg;
  logic [MAG_W-1:0]     mag;

  always_comb begin
    w_eff   = clamp_size(width_r);
    h_eff   = clamp_size(height_r);
    use_mid = (cx_cfg_r == '0) && (cy_cfg_r == '0);
    cx_eff  = use_mid ? (w_eff >> 1) : PW'(cx_cfg_r);
    cy_eff  = use_mid ? (h_eff >> 1) : PW'(cy_cfg_r);
    ctr_bad = (cx_eff > w_eff) || (cy_eff > h_eff);
    // furthest corner along each axis
    wrem    = $signed({2'b00, w_eff}) - $signed((PW+2)'(1)) - $signed({2'b00, cx_eff});
    hrem    = $signed({2'b00, h_eff}) - $signed((PW+2)'(1)) - $signed({2'b00, cy_eff});
    mx_eff  = (wrem > $signed({2'b00, cx_eff})) ? wrem[PW-1:0] : cx_eff;
    my_eff  = (hrem > $signed({2'b00, cy_eff})) ? hrem[PW-1:0] : cy_eff;
    aneg    = twist_r[TWIST_W-1];
    mag     = aneg ? MAG_W'(~twist_r + 1'b1) : MAG_W'(twist_r);
  end

  // ------------------------------------------------------------ flow control
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv       = !vld_r[NST-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ------------------------------------------- offset, squares, square sums
  side_t                  p0_side_nxt, p0_side_r, p1_side_r, p2_side_nxt, p2_side_r;
  logic [R2W-1:0]         p1_dx2_r, p1_dy2_r, p1_mx2_r, p1_my2_r, p2_r2_r, p2_rm2_r;
  logic signed [2*DW-1:0] dx2_full, dy2_full;
  logic [2*PW-1:0]        mx2_full, my2_full;
  logic [R2W-1:0]         r2_sum, rm2_sum;

  always_comb begin
    p0_side_nxt.col = COORD_BITS'(in_data.pixel_col);
    p0_side_nxt.row = COORD_BITS'(in_data.pixel_row);
    p0_side_nxt.dx  = $signed(DW'(p0_side_nxt.col)) - $signed(DW'(cx_eff));
    p0_side_nxt.dy  = $signed(DW'(p0_side_nxt.row)) - $signed(DW'(cy_eff));
    p0_side_nxt.far = 1'b0;
  end

  assign dx2_full = p0_side_r.dx * p0_side_r.dx;
  assign dy2_full = p0_side_r.dy * p0_side_r.dy;
  assign mx2_full = mx_eff * mx_eff;
  assign my2_full = my_eff * my_eff;
  assign r2_sum   = p1_dx2_r + p1_dy2_r;
  assign rm2_sum  = p1_mx2_r + p1_my2_r;

  // pixel beyond rmax: exact compare of the squares
  always_comb begin
    p2_side_nxt     = p1_side_r;
    p2_side_nxt.far = r2_sum > rm2_sum;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_side_r <= p0_side_nxt;
      p1_side_r <= p0_side_r;
      p1_dx2_r  <= dx2_full[R2W-1:0];
      p1_dy2_r  <= dy2_full[R2W-1:0];
      p1_mx2_r  <= mx2_full[R2W-1:0];
      p1_my2_r  <= my2_full[R2W-1:0];
      p2_side_r <= p2_side_nxt;
      p2_r2_r   <= r2_sum;
      p2_rm2_r  <= rm2_sum;
    end
  end

  // ----------------------------------------- square roots, one bit a stage
  sq_stage_t sq_r [RW];

  for (genvar gk = 0; gk < RW; gk++) begin : g_sqrt
    sq_stage_t sq_src, sq_nxt;
    if (gk == 0) begin : g_first
      assign sq_src = '{side: p2_side_r, r2: p2_r2_r, rm2: p2_rm2_r, a: '0, b: '0};
    end else begin : g_next
      assign sq_src = sq_r[gk-1];
    end
    always_comb begin
      sq_nxt   = sq_src;
      sq_nxt.a = sq_step(sq_src.a, get_pair(sq_src.r2, RW - 1 - gk));
      sq_nxt.b = sq_step(sq_src.b, get_pair(sq_src.rm2, RW - 1 - gk));
    end
    always_ff @(posedge clk) begin
      if (adv) sq_r[gk] <= sq_nxt;
    end
  end

  // ------------------------------------------ twist numerator |alpha|*(R-r)
  dv_stage_t        mul_r;
  logic [RW-1:0]    r_diff;
  logic [NUM_W-1:0] num_full;

  assign r_diff   = sq_r[RW-1].b.res - sq_r[RW-1].a.res;
  assign num_full = mag * r_diff;

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_r.side <= sq_r[RW-1].side;
      mul_r.num  <= num_full;
      mul_r.div  <= sq_r[RW-1].b.res;
      mul_r.rem  <= num_full[NUM_W-1 -: RW];
      mul_r.q    <= '0;
    end
  end

  // ------------------------------------ restoring division, one quotient bit
  dv_stage_t dv_r [QW];

  for (genvar gq = 0; gq < QW; gq++) begin : g_div
    dv_stage_t     dv_src, dv_nxt;
    logic [RW:0]   acc;
    if (gq == 0) begin : g_first
      assign dv_src = mul_r;
    end else begin : g_next
      assign dv_src = dv_r[gq-1];
    end
    always_comb begin
      dv_nxt = dv_src;
      acc    = {dv_src.rem, div_bit(dv_src.num, QW - 1 - gq)};
      if (acc >= {1'b0, dv_src.div}) begin
        dv_nxt.rem = RW'(acc - {1'b0, dv_src.div});
        dv_nxt.q   = {dv_src.q[QW-2:0], 1'b1};
      end else begin
        dv_nxt.rem = acc[RW-1:0];
        dv_nxt.q   = {dv_src.q[QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dv_r[gq] <= dv_nxt;
    end
  end

  // ------------------------------------- angle sign and wrap, gain, quadrant
  cd_stage_t            z_r, gain_r, quad_r, quad_nxt;
  logic signed [ZW-1:0] tw, z0, z1, z2;
  logic signed [XW-1:0] gx_full, gy_full;

  always_comb begin
    tw = (dv_r[QW-1].div == '0) ? '0 : $signed({2'b00, dv_r[QW-1].q});
    z0 = aneg ? -tw : tw;
    z1 = (z0 > ANG_PI) ? z0 - ANG_TWO_PI : z0;
    z2 = (z1 < -ANG_PI) ? z1 + ANG_TWO_PI : z1;
  end

  assign gx_full = z_r.side.dx * INV_GAIN;
  assign gy_full = z_r.side.dy * INV_GAIN;

  always_comb begin
    quad_nxt = gain_r;
    if (gain_r.z > ANG_HALF_PI) begin
      quad_nxt.x = -gain_r.y;
      quad_nxt.y = gain_r.x;
      quad_nxt.z = gain_r.z - ANG_HALF_PI;
    end else if (gain_r.z < -ANG_HALF_PI) begin
      quad_nxt.x = gain_r.y;
      quad_nxt.y = -gain_r.x;
      quad_nxt.z = gain_r.z + ANG_HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_r.side    <= dv_r[QW-1].side;
      z_r.x       <= '0;
      z_r.y       <= '0;
      z_r.z       <= z2;
      gain_r.side <= z_r.side;
      gain_r.x    <= gx_full;
      gain_r.y    <= gy_full;
      gain_r.z    <= z_r.z;
      quad_r      <= quad_nxt;
    end
  end

  // ----------------------------------------------- CORDIC, one step a stage
  cd_stage_t cd_r [NSTEP];

  for (genvar gc = 0; gc < NSTEP; gc++) begin : g_cordic
    cd_stage_t            cd_src, cd_nxt;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;
    if (gc == 0) begin : g_first
      assign cd_src = quad_r;
    end else begin : g_next
      assign cd_src = cd_r[gc-1];
    end
    always_comb begin
      cd_nxt = cd_src;
      xs     = cd_src.x >>> gc;
      ys     = cd_src.y >>> gc;
      ang    = $signed(ZW'(ATAN_Q30[gc]));
      if (!cd_src.z[ZW-1]) begin
        cd_nxt.x = cd_src.x - ys;
        cd_nxt.y = cd_src.y + xs;
        cd_nxt.z = cd_src.z - ang;
      end else begin
        cd_nxt.x = cd_src.x + ys;
        cd_nxt.y = cd_src.y - xs;
        cd_nxt.z = cd_src.z + ang;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) cd_r[gc] <= cd_nxt;
    end
  end

  // ------------------------------------------- rounding, centre add, output
  out_item_t            out_nxt, out_data_r;
  logic signed [XW-1:0] rx, ry, sx, sy, ix, iy;
  logic                 ident;

  always_comb begin
    rx    = (cd_r[NSTEP-1].x + RND) >>> RSH;
    ry    = (cd_r[NSTEP-1].y + RND) >>> RSH;
    sx    = $signed(XW'({cx_eff, FRAC_BITS'(0)})) + rx;
    sy    = $signed(XW'({cy_eff, FRAC_BITS'(0)})) + ry;
    ix    = $signed(XW'({cd_r[NSTEP-1].side.col, FRAC_BITS'(0)}));
    iy    = $signed(XW'({cd_r[NSTEP-1].side.row, FRAC_BITS'(0)}));
    ident = ctr_bad || cd_r[NSTEP-1].side.far;
    out_nxt.source_x       = sat_out(ident ? ix : sx);
    out_nxt.source_y       = sat_out(ident ? iy : sy);
    out_nxt.center_invalid = ctr_bad;
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_nxt;
  end

  assign out_data = out_data_r;

  // ---------------------------------------------------------------- checks
  `TWMG_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stalled with output free")
  `TWMG_ASSERT_NXT(a_last_stage_lands, vld_r[NST-2] && !in_stall, out_valid, "transaction lost before output")
  `TWMG_ASSERT_IMP(a_bad_centre_identity, out_valid && out_data.center_invalid, !out_data.source_x[OUT_W-1] && !out_data.source_y[OUT_W-1], "negative source with bad centre")

endmodule
